>>> hw/rtl/ilir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Types and constants shared by the indexed list blocks.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int POS_WIDTH   = 5;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 5;

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_INSERT     = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_POP_FRONT  = 3'd4,
        ACT_REMOVE_AT  = 3'd5,
        ACT_CLEAR      = 3'd6,
        ACT_READ       = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] item_value;
        logic [POS_WIDTH-1:0]   position;
        action_t                action;
    } req_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        status_t                status;
        logic [VALUE_WIDTH-1:0] read_data;
    } rsp_t;

endpackage

>>> hw/rtl/ilir_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_list_core
// Slot array and entry count; executes one request per enabled cycle.
// ----------------------------------------------------------------------------
module ilir_list_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_WIDTH  = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 exec_valid,
    input  ilir_pkg::req_t       req,
    output ilir_pkg::rsp_t       rsp,
    output logic [CNT_WIDTH-1:0] entry_count
);
    import ilir_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W  = (CNT_WIDTH > POS_WIDTH) ? CNT_WIDTH : POS_WIDTH;

    logic [DATA_WIDTH-1:0] slots_reg [DEPTH];
    logic [DATA_WIDTH-1:0] slot_next [DEPTH];
    logic [DEPTH-1:0]      slot_we;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;

    logic [W-1:0]            count_w;
    logic [W-1:0]            tgt;
    logic                    do_ins;
    logic                    do_rem;
    status_t                 st;
    logic [VALUE_WIDTH-1:0]  rd;
    logic signed [DATA_WIDTH-1:0] rd_slot;
    logic [DATA_WIDTH-1:0]   wr_value;

    assign count_w     = W'(count_reg);
    assign wr_value    = DATA_WIDTH'(signed'(req.item_value));
    assign rd_slot     = signed'(slots_reg[tgt[AW-1:0]]);
    assign entry_count = count_reg;

    always_comb begin
        tgt        = W'(req.position);
        st         = ST_OK;
        rd         = '0;
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        count_next = count_reg;
        unique case (req.action) inside
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
                if (req.action == ACT_PUSH_BACK) begin
                    tgt = count_w;
                end else if (req.action == ACT_PUSH_FRONT) begin
                    tgt = '0;
                end
                if (tgt > count_w) begin
                    st = ST_RANGE;
                end else if (count_w >= W'(DEPTH)) begin
                    st = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT, ACT_REMOVE_AT: begin
                if (req.action == ACT_POP_BACK) begin
                    tgt = count_w - 1'b1;
                end else if (req.action == ACT_POP_FRONT) begin
                    tgt = '0;
                end
                if (count_reg == '0) begin
                    st = ST_EMPTY;
                end else if (tgt >= count_w) begin
                    st = ST_RANGE;
                end else begin
                    do_rem     = 1'b1;
                    rd         = VALUE_WIDTH'(rd_slot);
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_CLEAR: begin
                count_next = '0;
            end
            default: begin
                if (tgt >= count_w) begin
                    st = ST_RANGE;
                end else begin
                    rd = VALUE_WIDTH'(rd_slot);
                end
            end
        endcase
    end

    assign rsp.read_data = rd;
    assign rsp.status    = st;
    assign rsp.count     = COUNT_WIDTH'(count_next);

    // Insert opens a gap at the target by moving the slots above it up one
    // place; remove closes it by moving them down.
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        localparam logic [W-1:0] IDX = W'(i);
        localparam logic [W-1:0] IDX_NEXT = W'(i + 1);
        logic [DATA_WIDTH-1:0] below;
        logic [DATA_WIDTH-1:0] above;
        logic                  has_below;
        logic                  has_above;

        if (i == 0) begin : g_first
            assign below     = '0;
            assign has_below = 1'b0;
        end else begin : g_mid_lo
            assign below     = slots_reg[i-1];
            assign has_below = 1'b1;
        end
        if (i == DEPTH - 1) begin : g_last
            assign above     = '0;
            assign has_above = 1'b0;
        end else begin : g_mid_hi
            assign above     = slots_reg[i+1];
            assign has_above = 1'b1;
        end

        always_comb begin
            slot_next[i] = slots_reg[i];
            slot_we[i]   = 1'b0;
            if (do_ins) begin
                if (IDX == tgt) begin
                    slot_next[i] = wr_value;
                    slot_we[i]   = 1'b1;
                end else if (has_below && IDX > tgt && IDX <= count_w) begin
                    slot_next[i] = below;
                    slot_we[i]   = 1'b1;
                end
            end else if (do_rem) begin
                if (has_above && IDX >= tgt && IDX_NEXT < count_w) begin
                    slot_next[i] = above;
                    slot_we[i]   = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (exec_valid && slot_we[i]) begin
                slots_reg[i] <= slot_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec_valid) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/indexed_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded ordered list with push, pop, insert, remove, clear and read.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  action, position, item_value
//  m_       out  m_tvalid/m_tready  read_data, status, count
//
//  One word is accepted per cycle while the result is not stalled; the
//  request stage registers the word and the output stage registers its result.
//  The slot array shifts all slots above the position in the same update
//  that changes the entry count.
//  Reset clears the entry count and both stage valids; slots need no reset.
//  A stalled result holds the request stage, which then stops s_tready.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[2:0], position[7:3], item_value[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[31:0], status[33:32], count[38:34]
);
    import ilir_pkg::*;

    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    logic                 in_valid_reg;
    req_t                 req_reg;
    logic                 out_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp;
    logic                 advance;
    logic                 exec_valid;
    logic [CNT_WIDTH-1:0] entry_count;
    req_t                 s_req;

    assign s_req.action     = action_t'(s_tdata[2:0]);
    assign s_req.position   = s_tdata[7:3];
    assign s_req.item_value = s_tdata[39:8];

    assign advance    = !out_valid_reg || m_tready;
    assign exec_valid = in_valid_reg && advance;
    assign s_tready   = !in_valid_reg || advance;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0, rsp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg <= s_req;
        end
    end

    ilir_list_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_WIDTH  (CNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec_valid  (exec_valid),
        .req         (req_reg),
        .rsp         (rsp),
        .entry_count (entry_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_valid) begin
            rsp_reg <= rsp;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= CNT_WIDTH'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !exec_valid |=> $stable(entry_count))
        else $error("entry count changed without a request");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && rsp_reg.status == ST_FULL) |-> rsp_reg.count == COUNT_WIDTH'(DEPTH))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && rsp_reg.status == ST_EMPTY) |-> rsp_reg.count == '0)
        else $error("empty status with entries present");

endmodule
